// ===== rtl/core/loc_pkg.sv =====
package loc_pkg;

   // Sizing of the held-lock stack.
   localparam int MAX_HELD    = 16;
   localparam int LEVEL_WIDTH = 8;
   localparam int ID_WIDTH    = 64;

   localparam int IDX_W   = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
   localparam int CNT_W   = $clog2(MAX_HELD + 1);
   localparam int ENTRY_W = ID_WIDTH + LEVEL_WIDTH;

   // Operation codes.
   localparam logic [1:0] OP_CHECK   = 2'd0;
   localparam logic [1:0] OP_ACQUIRE = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // Lock kinds.
   localparam logic [1:0] KIND_TOKEN = 2'd2;

   // Result status codes.
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_REACQUIRE = 3'd1;
   localparam logic [2:0] STS_ORDER     = 3'd2;
   localparam logic [2:0] STS_FULL      = 3'd3;
   localparam logic [2:0] STS_NOT_TOP   = 3'd4;
   localparam logic [2:0] STS_NOT_HELD  = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic scan;
      logic shift;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic shift_done;
      logic need_shift;
   } ctl_status_type;

endpackage

// ===== rtl/core/loc_req_if.sv =====
interface loc_req_if;

   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [63:0] lock_id;
   logic [7:0]  lock_level;
   logic [1:0]  lock_kind;

   modport source (output valid, output opcode, output lock_id, output lock_level,
                   output lock_kind, input ready);
   modport sink   (input valid, input opcode, input lock_id, input lock_level,
                   input lock_kind, output ready);

endinterface

// ===== rtl/core/loc_rsp_if.sv =====
interface loc_rsp_if;

   logic        valid;
   logic        ready;
   logic        safe;
   logic [2:0]  status;
   logic [4:0]  held_count;
   logic [7:0]  top_level;
   logic [4:0]  peak_held;
   logic [31:0] violation_count;
   logic [31:0] check_count;
   logic [31:0] acquire_count;

   modport source (output valid, output safe, output status, output held_count,
                   output top_level, output peak_held, output violation_count,
                   output check_count, output acquire_count, input ready);
   modport sink   (input valid, input safe, input status, input held_count,
                   input top_level, input peak_held, input violation_count,
                   input check_count, input acquire_count, output ready);

endinterface

// ===== rtl/core/lock_order_checker.sv =====
// Lock order checker for one thread's stack of up to sixteen held locks. Each
// request beat carries an opcode (check, acquire or release) and gives exactly
// one response beat with the verdict, the status code and the counters as they
// stand after the operation. The stack lives in a single-port-read memory that
// is visited one entry per cycle: a check walks all held entries upwards, a
// release walks them down from the top and, when the lock is found below the
// top, then moves the entries above it down (the search from the top and then
// the compaction). An acquire, any operation on an empty stack and any
// operation while checking is disabled reads no entry. One request is worked
// on at a time; a new request is taken while the previous response still
// waits in the output register. The enable register is written through
// csr_write_enable and csr_write_data and should only be changed while no
// request is in flight.
module lock_order_checker (
   input  logic   clock,
   input  logic   reset,
   loc_req_if.sink   req_ch,
   loc_rsp_if.source rsp_ch,
   input  logic   csr_write_enable,
   input  logic   csr_write_data
);

   import loc_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type stat;

   // Sequencer.
   loc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Stack, counters and result register.
   loc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .opcode           (req_ch.opcode),
      .lock_id          (req_ch.lock_id),
      .lock_level       (req_ch.lock_level),
      .lock_kind        (req_ch.lock_kind),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .safe             (rsp_ch.safe),
      .status           (rsp_ch.status),
      .held_count       (rsp_ch.held_count),
      .top_level        (rsp_ch.top_level),
      .peak_held        (rsp_ch.peak_held),
      .violation_count  (rsp_ch.violation_count),
      .check_count      (rsp_ch.check_count),
      .acquire_count    (rsp_ch.acquire_count)
   );

endmodule

// ===== rtl/core/loc_ram.sv =====
module loc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/loc_datapath.sv =====
module loc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           opcode,
   input  logic [63:0]          lock_id,
   input  logic [7:0]           lock_level,
   input  logic [1:0]           lock_kind,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  loc_pkg::ctl_cmd_type cmd,
   output loc_pkg::ctl_status_type stat,
   output logic                 safe,
   output logic [2:0]           status,
   output logic [4:0]           held_count,
   output logic [7:0]           top_level,
   output logic [4:0]           peak_held,
   output logic [31:0]          violation_count,
   output logic [31:0]          check_count,
   output logic [31:0]          acquire_count
);

   import loc_pkg::*;

   // Latched request.
   logic [1:0]             op_ff;
   logic [ID_WIDTH-1:0]    id_ff;
   logic [LEVEL_WIDTH-1:0] level_ff;
   logic [1:0]             kind_ff;

   // Architectural state.
   logic                   en_ff;
   logic [CNT_W-1:0]       depth_ff, depth_in;
   logic [LEVEL_WIDTH-1:0] top_ff, top_in;
   logic [CNT_W-1:0]       peak_ff, peak_in;
   logic [31:0]            viol_ff, viol_in;
   logic [31:0]            chk_ff, chk_in;
   logic [31:0]            acq_ff, acq_in;

   // Scan and compaction state.
   logic [CNT_W-1:0]       len_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   pend_ff;
   logic [IDX_W-1:0]       pidx_ff;
   logic                   found_ff;
   logic                   le_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic [LEVEL_WIDTH-1:0] max_ff;
   logic [CNT_W-1:0]       sh_ff;

   // Result register.
   logic                   safe_ff, safe_in;
   logic [2:0]             status_ff, status_in;
   logic [4:0]             held_ff;
   logic [7:0]             top_out_ff;
   logic [4:0]             peak_out_ff;
   logic [31:0]            viol_out_ff, chk_out_ff, acq_out_ff;

   // Memory port signals.
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_data;

   logic                   is_release;
   logic                   scan_issue, shift_issue, shift_wr;
   logic [CNT_W-1:0]       scan_pos;
   logic [ID_WIDTH-1:0]    rd_id;
   logic [LEVEL_WIDTH-1:0] rd_lvl;
   logic                   rd_hit;
   logic                   acq_ok;
   logic                   scan_req;

   // Stack storage: identifier above level in each entry.
   loc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_HELD)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id  = rd_data[ENTRY_W-1:LEVEL_WIDTH];
   assign rd_lvl = rd_data[LEVEL_WIDTH-1:0];
   assign rd_hit = (rd_id == id_ff);

   assign is_release = en_ff && (op_ff == OP_RELEASE);
   assign scan_req   = en_ff && ((opcode == OP_CHECK) || (opcode == OP_RELEASE));
   assign acq_ok     = en_ff && (op_ff == OP_ACQUIRE) && (depth_ff < CNT_W'(MAX_HELD));

   // A check walks the stack upwards, a release walks it down from the top.
   assign scan_pos    = is_release ? (len_ff - CNT_W'(1) - cnt_ff) : cnt_ff;
   assign scan_issue  = cmd.scan && (cnt_ff != len_ff);
   assign shift_issue = cmd.shift && (sh_ff != depth_ff);
   assign shift_wr    = cmd.shift && pend_ff;

   always_comb begin
      rd_en   = scan_issue || shift_issue;
      rd_addr = scan_issue ? scan_pos[IDX_W-1:0] : sh_ff[IDX_W-1:0];
      if (shift_wr) begin
         wr_en   = 1'b1;
         wr_addr = pidx_ff - IDX_W'(1);
         wr_data = rd_data;
      end else begin
         wr_en   = cmd.commit && acq_ok;
         wr_addr = depth_ff[IDX_W-1:0];
         wr_data = {id_ff, level_ff};
      end
   end

   // Status back to the controller.
   assign stat.scan_done  = (cnt_ff == len_ff) && !pend_ff;
   assign stat.shift_done = (sh_ff == depth_ff) && !pend_ff;
   assign stat.need_shift = is_release && found_ff;

   // Outcome of the operation once all reads are done.
   always_comb begin
      safe_in   = 1'b1;
      status_in = STS_OK;
      depth_in  = depth_ff;
      top_in    = top_ff;
      peak_in   = peak_ff;
      viol_in   = viol_ff;
      chk_in    = chk_ff;
      acq_in    = acq_ff;
      if (en_ff) begin
         case (op_ff)
            OP_CHECK: begin
               chk_in = chk_ff + 32'd1;
               if (found_ff) begin
                  if (kind_ff != KIND_TOKEN) begin
                     safe_in   = 1'b0;
                     status_in = STS_REACQUIRE;
                  end
               end else if (le_ff) begin
                  safe_in   = 1'b0;
                  status_in = STS_ORDER;
                  viol_in   = viol_ff + 32'd1;
               end
            end
            OP_ACQUIRE: begin
               if (!acq_ok) begin
                  status_in = STS_FULL;
               end else begin
                  depth_in = depth_ff + CNT_W'(1);
                  if (depth_in > peak_ff) begin
                     peak_in = depth_in;
                  end
                  if (level_ff > top_ff) begin
                     top_in = level_ff;
                  end
                  acq_in = acq_ff + 32'd1;
               end
            end
            OP_RELEASE: begin
               if (!found_ff) begin
                  status_in = STS_NOT_HELD;
               end else begin
                  if (CNT_W'(pos_ff) != (depth_ff - CNT_W'(1))) begin
                     status_in = STS_NOT_TOP;
                  end
                  depth_in = depth_ff - CNT_W'(1);
                  top_in   = max_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration register and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b1;
         depth_ff <= '0;
         top_ff   <= '0;
         peak_ff  <= '0;
         viol_ff  <= '0;
         chk_ff   <= '0;
         acq_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            en_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            depth_ff <= depth_in;
            top_ff   <= top_in;
            peak_ff  <= peak_in;
            viol_ff  <= viol_in;
            chk_ff   <= chk_in;
            acq_ff   <= acq_in;
         end
      end
   end

   // Read pipeline tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= rd_en;
      end
      pidx_ff <= rd_addr;
   end

   // Request latch, scan accumulators and compaction pointer.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= opcode;
         id_ff    <= ID_WIDTH'(lock_id);
         level_ff <= LEVEL_WIDTH'(lock_level);
         kind_ff  <= lock_kind;
         len_ff   <= scan_req ? depth_ff : '0;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
         le_ff    <= 1'b0;
         max_ff   <= '0;
      end else begin
         if (scan_issue) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (shift_issue) begin
            sh_ff <= sh_ff + CNT_W'(1);
         end
         if (cmd.scan && pend_ff) begin
            if (level_ff <= rd_lvl) begin
               le_ff <= 1'b1;
            end
            // The first hit seen from the top is removed; all others count
            // towards the new highest level.
            if (rd_hit && !found_ff) begin
               found_ff <= 1'b1;
               pos_ff   <= pidx_ff;
               sh_ff    <= CNT_W'(pidx_ff) + CNT_W'(1);
            end else if (rd_lvl > max_ff) begin
               max_ff <= rd_lvl;
            end
         end
      end
   end

   // Result register, loaded with the state after the operation.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         safe_ff     <= safe_in;
         status_ff   <= status_in;
         held_ff     <= 5'(depth_in);
         top_out_ff  <= 8'(top_in);
         peak_out_ff <= 5'(peak_in);
         viol_out_ff <= viol_in;
         chk_out_ff  <= chk_in;
         acq_out_ff  <= acq_in;
      end
   end

   assign safe            = safe_ff;
   assign status          = status_ff;
   assign held_count      = held_ff;
   assign top_level       = top_out_ff;
   assign peak_held       = peak_out_ff;
   assign violation_count = viol_out_ff;
   assign check_count     = chk_out_ff;
   assign acquire_count   = acq_out_ff;

endmodule

// ===== rtl/core/loc_controller.sv =====
module loc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  loc_pkg::ctl_status_type stat,
   output loc_pkg::ctl_cmd_type    cmd
);

   import loc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   // Commands decoded from the current state.
   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.shift  = (state_ff == ST_SHIFT);
   assign cmd.commit = (state_ff == ST_DONE) && slot_free;

   // Sequencer and result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The result flag is set by a commit and cleared once its beat is taken.
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (stat.scan_done) begin
                  state_ff <= stat.need_shift ? ST_SHIFT : ST_DONE;
               end
            end
            ST_SHIFT: begin
               if (stat.shift_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/loc_checker.sv =====
module loc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic [1:0] outstanding_ff;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Requests taken whose response beat has not yet gone out.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 2'd0;
      end else if (req_beat && !rsp_beat) begin
         outstanding_ff <= outstanding_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         outstanding_ff <= outstanding_ff - 2'd1;
      end
   end

   // No response is offered straight after reset.
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every response answers a request that was taken.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("response without a request");

   // At most one request in work and one response waiting.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff != 2'd3)
      else $error("too many requests in flight");

endmodule

bind lock_order_checker loc_checker u_loc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import loc_pkg::*;

   // Codes that the package does not name.
   localparam logic [1:0] OP_NONE    = 2'd3;
   localparam logic [1:0] KIND_SPIN  = 2'd0;
   localparam logic [1:0] KIND_MUTEX = 2'd1;
   localparam logic [1:0] KIND_SLEEP = 2'd3;

   localparam int PHASES        = 6;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 2 * MAX_HELD + 8;
   localparam int PRINT_LIMIT   = 40;

   typedef struct {
      logic [1:0]  opcode;
      logic [63:0] lock_id;
      logic [7:0]  lock_level;
      logic [1:0]  lock_kind;
   } lock_beat_type;

   typedef struct {
      logic        safe;
      logic [2:0]  status;
      logic [4:0]  held_count;
      logic [7:0]  top_level;
      logic [4:0]  peak_held;
      logic [31:0] violation_count;
      logic [31:0] check_count;
      logic [31:0] acquire_count;
   } lock_verdict_type;

   // One line of the directed table, or one random beat. Where pinned is set the
   // typed-in verdict fields replace those that the stack model works out.
   typedef struct {
      lock_beat_type beat;
      int         count;
      bit         enable;
      bit         pinned;
      bit         safe;
      bit [2:0]   status;
      bit [4:0]   held;
      bit [7:0]   top;
   } lock_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   loc_req_if req_ch ();
   loc_rsp_if rsp_ch ();

   lock_order_checker dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Own copy of the held-lock stack, its totals and the enable register.
   logic [63:0]          stack_ids    [MAX_HELD];
   logic [LEVEL_WIDTH-1:0] stack_levels [MAX_HELD];
   int                   stack_depth;
   logic [7:0]           stack_top;
   logic [4:0]           stack_peak;
   logic [31:0]          violations_seen;
   logic [31:0]          checks_seen;
   logic [31:0]          acquires_seen;
   bit                   checking_on;

   lock_verdict_type verdicts_due [$];
   lock_row_type     directed_rows [$];
   logic [63:0]   id_pool [8];

   int mismatches;
   int verdicts_seen;
   bit long_hold_wanted;
   bit sender_burst;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Hard stop in case the handshakes never complete.
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at response beat %0d: %s got %0h expected %0h",
                  verdicts_seen, what, got, want);
      mismatches++;
   endtask

   // Works out the verdict of one beat and advances the stack model.
   function automatic lock_verdict_type apply_lock_beat(lock_beat_type b);
      lock_verdict_type v;
      bit            found;
      bit            order_hit;
      int            pos;
      v.safe   = 1'b1;
      v.status = STS_OK;
      found     = 1'b0;
      order_hit = 1'b0;
      pos       = -1;
      if (checking_on) begin
         case (b.opcode)
            OP_CHECK: begin
               checks_seen++;
               for (int i = 0; i < stack_depth; i++)
                  if (stack_ids[i] == b.lock_id) found = 1'b1;
               if (found) begin
                  // A token may be taken again; any other kind may not.
                  if (b.lock_kind != KIND_TOKEN) begin
                     v.safe   = 1'b0;
                     v.status = STS_REACQUIRE;
                  end
               end else begin
                  for (int i = 0; i < stack_depth; i++)
                     if (b.lock_level <= stack_levels[i]) order_hit = 1'b1;
                  if (order_hit) begin
                     v.safe   = 1'b0;
                     v.status = STS_ORDER;
                     violations_seen++;
                  end
               end
            end
            OP_ACQUIRE: begin
               if (stack_depth >= MAX_HELD) begin
                  v.status = STS_FULL;
               end else begin
                  stack_ids[stack_depth]    = b.lock_id;
                  stack_levels[stack_depth] = b.lock_level;
                  stack_depth++;
                  if (stack_depth > int'(stack_peak)) stack_peak = 5'(stack_depth);
                  if (b.lock_level > stack_top) stack_top = b.lock_level;
                  acquires_seen++;
               end
            end
            OP_RELEASE: begin
               // Search from the top; the first match is the one removed.
               for (int i = stack_depth - 1; i >= 0; i--)
                  if (pos < 0 && stack_ids[i] == b.lock_id) pos = i;
               if (pos < 0) begin
                  v.status = STS_NOT_HELD;
               end else begin
                  if (pos != stack_depth - 1) v.status = STS_NOT_TOP;
                  for (int i = pos; i < stack_depth - 1; i++) begin
                     stack_ids[i]    = stack_ids[i + 1];
                     stack_levels[i] = stack_levels[i + 1];
                  end
                  stack_depth--;
                  stack_top = '0;
                  for (int i = 0; i < stack_depth; i++)
                     if (stack_levels[i] > stack_top) stack_top = stack_levels[i];
               end
            end
            default: begin
            end
         endcase
      end
      v.held_count      = 5'(stack_depth);
      v.top_level       = stack_top;
      v.peak_held       = stack_peak;
      v.violation_count = violations_seen;
      v.check_count     = checks_seen;
      v.acquire_count   = acquires_seen;
      return v;
   endfunction

   task automatic add_row(logic [1:0] op, logic [63:0] id, logic [7:0] level,
                          logic [1:0] kind, int count, bit enable, bit pinned,
                          bit safe, bit [2:0] status, bit [4:0] held, bit [7:0] top);
      lock_row_type row;
      row.beat.opcode     = op;
      row.beat.lock_id    = id;
      row.beat.lock_level = level;
      row.beat.lock_kind  = kind;
      row.count  = count;
      row.enable = enable;
      row.pinned = pinned;
      row.safe   = safe;
      row.status = status;
      row.held   = held;
      row.top    = top;
      directed_rows.push_back(row);
   endtask

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (sender_burst || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Random beat; mostly pool identifiers and rising levels so that deep stacks,
   // re-takes and releases below the top come up often.
   function automatic lock_row_type random_row(int w_check, int w_acquire, bit enable);
      lock_row_type row;
      int        r;
      int        t;
      r = $urandom_range(0, 99);
      t = int'(stack_top);
      if (r < w_check)                  row.beat.opcode = OP_CHECK;
      else if (r < w_check + w_acquire) row.beat.opcode = OP_ACQUIRE;
      else if (r < 97)                  row.beat.opcode = OP_RELEASE;
      else                              row.beat.opcode = OP_NONE;
      if (row.beat.opcode == OP_RELEASE && stack_depth > 0 && $urandom_range(0, 9) < 8)
         row.beat.lock_id = stack_ids[$urandom_range(0, stack_depth - 1)];
      else if ($urandom_range(0, 9) < 7)
         row.beat.lock_id = id_pool[$urandom_range(0, 7)];
      else
         row.beat.lock_id = {$urandom, $urandom};
      if (t < 255 && $urandom_range(0, 9) < 7)
         row.beat.lock_level = 8'($urandom_range(t + 1, (t > 231) ? 255 : t + 24));
      else
         row.beat.lock_level = 8'($urandom_range(0, 255));
      row.beat.lock_kind = 2'($urandom_range(0, 3));
      row.count  = 1;
      row.enable = enable;
      row.pinned = 1'b0;
      row.safe   = 1'b0;
      row.status = '0;
      row.held   = '0;
      row.top    = '0;
      return row;
   endfunction

   // Offers one request beat, after a gap or after draining the block (and a
   // write of the enable register where the row asks for another setting).
   task automatic issue_beat(lock_row_type row, bit drain_first);
      lock_verdict_type want;
      int            gap;
      if (drain_first || row.enable != checking_on) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (verdicts_due.size() != 0);
         if (row.enable != checking_on) begin
            csr_write_enable <= 1'b1;
            csr_write_data   <= row.enable;
            @(posedge clock);
            csr_write_enable <= 1'b0;
            checking_on = row.enable;
         end
      end else begin
         gap = sender_gap();
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= row.beat.opcode;
      req_ch.lock_id    <= row.beat.lock_id;
      req_ch.lock_level <= row.beat.lock_level;
      req_ch.lock_kind  <= row.beat.lock_kind;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      want = apply_lock_beat(row.beat);
      if (row.pinned) begin
         want.safe       = row.safe;
         want.status     = row.status;
         want.held_count = row.held;
         want.top_level  = row.top;
      end
      verdicts_due.push_back(want);
   endtask

   // Response side: random stalls, the odd steady stretch, and one long hold.
   initial begin
      int stall_left;
      int steady_left;
      int r;
      stall_left  = 0;
      steady_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         r = $urandom_range(0, 99);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            stall_left       = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (steady_left > 0) begin
            rsp_ch.ready <= 1'b1;
            steady_left--;
         end else if (r < 70) begin
            rsp_ch.ready <= 1'b1;
         end else if (r < 95) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else if (r < 98) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(10, 40);
         end else begin
            rsp_ch.ready <= 1'b1;
            steady_left = $urandom_range(20, 80);
         end
      end
   end

   // Each accepted response beat is compared with the oldest verdict due.
   always @(posedge clock) begin
      lock_verdict_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch("response beat with nothing outstanding", 0, 0);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_ch.safe !== want.safe)
               report_mismatch("safe", rsp_ch.safe, want.safe);
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (rsp_ch.held_count !== want.held_count)
               report_mismatch("held_count", rsp_ch.held_count, want.held_count);
            if (rsp_ch.top_level !== want.top_level)
               report_mismatch("top_level", rsp_ch.top_level, want.top_level);
            if (rsp_ch.peak_held !== want.peak_held)
               report_mismatch("peak_held", rsp_ch.peak_held, want.peak_held);
            if (rsp_ch.violation_count !== want.violation_count)
               report_mismatch("violation_count", rsp_ch.violation_count,
                               want.violation_count);
            if (rsp_ch.check_count !== want.check_count)
               report_mismatch("check_count", rsp_ch.check_count, want.check_count);
            if (rsp_ch.acquire_count !== want.acquire_count)
               report_mismatch("acquire_count", rsp_ch.acquire_count, want.acquire_count);
         end
         verdicts_seen++;
      end
   end

   initial begin
      lock_row_type row;
      int        n_items;
      int        w_check;
      int        w_acquire;
      bit        phase_enable;
      int        waited;

      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_CHECK;
      req_ch.lock_id     = '0;
      req_ch.lock_level  = '0;
      req_ch.lock_kind   = KIND_SPIN;
      mismatches         = 0;
      verdicts_seen      = 0;
      long_hold_wanted   = 1'b0;
      sender_burst       = 1'b0;

      // State of the model after reset.
      stack_depth     = 0;
      stack_top       = '0;
      stack_peak      = '0;
      violations_seen = '0;
      checks_seen     = '0;
      acquires_seen   = '0;
      checking_on     = 1'b1;

      // Directed table: op, id, level, kind, count, enable, pinned, then the
      // typed-in safe, status, held count and top level.
      add_row(OP_CHECK,   64'h0, 8'h00, KIND_SPIN,  1, 1, 1, 1, STS_OK,        0, 8'h00);
      add_row(OP_RELEASE, 64'h5, 8'h00, KIND_SPIN,  1, 1, 1, 1, STS_NOT_HELD,  0, 8'h00);
      add_row(OP_ACQUIRE, 64'h0, 8'h00, KIND_SPIN,  1, 1, 1, 1, STS_OK,        1, 8'h00);
      add_row(OP_CHECK,   64'h0, 8'h00, KIND_TOKEN, 1, 1, 1, 1, STS_OK,        1, 8'h00);
      add_row(OP_CHECK,   64'h0, 8'h00, KIND_MUTEX, 1, 1, 1, 0, STS_REACQUIRE, 1, 8'h00);
      add_row(OP_CHECK,   64'h1, 8'h00, KIND_SPIN,  1, 1, 1, 0, STS_ORDER,     1, 8'h00);
      add_row(OP_ACQUIRE, '1,    8'hFF, KIND_SLEEP, 1, 1, 1, 1, STS_OK,        2, 8'hFF);
      add_row(OP_CHECK,   64'h5555_5555_5555_5555, 8'hFF, KIND_SPIN, 1, 1, 1,
              0, STS_ORDER, 2, 8'hFF);
      add_row(OP_CHECK,   '1,    8'h00, KIND_TOKEN, 1, 1, 1, 1, STS_OK,        2, 8'hFF);
      add_row(OP_RELEASE, 64'h0, 8'h00, KIND_SPIN,  1, 1, 1, 1, STS_NOT_TOP,   1, 8'hFF);
      add_row(OP_RELEASE, '1,    8'h00, KIND_SPIN,  1, 1, 1, 1, STS_OK,        0, 8'h00);
      add_row(OP_ACQUIRE, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, KIND_MUTEX, 1, 1, 1,
              1, STS_OK, 1, 8'h55);
      // The same lock pushed a second time, then released from the top.
      add_row(OP_ACQUIRE, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, KIND_SPIN, 1, 1, 1,
              1, STS_OK, 2, 8'hAA);
      add_row(OP_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00, KIND_SPIN, 1, 1, 1,
              1, STS_OK, 1, 8'h55);
      add_row(OP_NONE,    '1,    8'hFF, KIND_SLEEP, 1, 1, 1, 1, STS_OK,        1, 8'h55);
      add_row(OP_CHECK,   64'h1234, 8'h56, KIND_MUTEX, 1, 1, 1, 1, STS_OK,     1, 8'h55);
      // Fill the stack, then overflow it.
      add_row(OP_ACQUIRE, 64'h100, 8'h60, KIND_SPIN, 15, 1, 0, 0, STS_OK,      0, 8'h00);
      add_row(OP_ACQUIRE, 64'h200, 8'hF0, KIND_SPIN,  1, 1, 1, 1, STS_FULL,   16, 8'h6E);
      add_row(OP_CHECK,   64'h300, 8'hF0, KIND_SLEEP, 1, 1, 1, 1, STS_OK,     16, 8'h6E);
      add_row(OP_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00, KIND_SPIN, 1, 1, 1,
              1, STS_NOT_TOP, 15, 8'h6E);
      add_row(OP_RELEASE, 64'h10E, 8'h00, KIND_SPIN,  1, 1, 1, 1, STS_OK,     14, 8'h6D);
      // Checking switched off: everything is safe and the stack stays put.
      add_row(OP_CHECK,   64'h10D, 8'h00, KIND_MUTEX, 1, 0, 1, 1, STS_OK,     14, 8'h6D);
      add_row(OP_ACQUIRE, 64'h400, 8'h01, KIND_SPIN,  1, 0, 1, 1, STS_OK,     14, 8'h6D);
      add_row(OP_RELEASE, 64'h100, 8'h00, KIND_SPIN,  1, 0, 1, 1, STS_OK,     14, 8'h6D);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; a counted row steps its id and level.
      foreach (directed_rows[n]) begin
         for (int k = 0; k < directed_rows[n].count; k++) begin
            row = directed_rows[n];
            row.beat.lock_id    = row.beat.lock_id + 64'(k);
            row.beat.lock_level = row.beat.lock_level + 8'(k);
            issue_beat(row, 1'b0);
         end
      end

      // Random phases with their own mix of operations and register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin n_items = 260; w_check = 30; w_acquire = 50; phase_enable = 1; end
            1:       begin n_items = 260; w_check = 35; w_acquire = 35; phase_enable = 1; end
            2:       begin n_items = 100; w_check = 35; w_acquire = 35; phase_enable = 0; end
            3:       begin n_items = 260; w_check = 30; w_acquire = 25; phase_enable = 1; end
            4:       begin n_items = 260; w_check = 25; w_acquire = 55; phase_enable = 1; end
            default: begin n_items = 210; w_check = 35; w_acquire = 38; phase_enable = 1; end
         endcase
         for (int k = 0; k < 8; k++) id_pool[k] = {$urandom, $urandom};
         for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) sender_burst = ($urandom_range(0, 3) == 0);
            if (phase == 1 && i == 20) long_hold_wanted = 1'b1;
            issue_beat(random_row(w_check, w_acquire, phase_enable), phase == 0 && i == 100);
         end
      end
      req_ch.valid <= 1'b0;

      // Let the last responses come out, then watch for stray beats a while.
      waited = 0;
      while (verdicts_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (verdicts_due.size() != 0)
         report_mismatch("responses never delivered", 0, verdicts_due.size());

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
